// File: hdl/chained_hash_map_insert_find_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the chained hash map unit
// Clocked assertions with active-low reset gating.
// ----------------------------------------------------------------------------
`ifndef CHAINED_HASH_MAP_INSERT_FIND_UNIT_ASSERT_SVH
`define CHAINED_HASH_MAP_INSERT_FIND_UNIT_ASSERT_SVH

// same-cycle implication
`define CHMIF_ASSERT_SAME(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |-> (CONS)) \
        else $error("chmif assertion failed");

// next-cycle implication
`define CHMIF_ASSERT_NEXT(LBL, CLK, RSTN, ANTE, CONS) \
    LBL: assert property (@(posedge CLK) disable iff (!RSTN) (ANTE) |=> (CONS)) \
        else $error("chmif assertion failed");

`endif

// File: hdl/chmif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmif_pkg
// Shared widths, defaults and opcodes of the chained hash map unit.
// ----------------------------------------------------------------------------
package chmif_pkg;

    localparam int unsigned KEY_W = 64;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned OP_W  = 2;

    localparam int unsigned BUCKET_COUNT_DEFAULT   = 1024;
    localparam int unsigned ENTRY_CAPACITY_DEFAULT = 1024;

    localparam logic [OP_W-1:0] OP_FIND   = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

endpackage

// File: hdl/chmif_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chmif_mod_unit
// Bucket select: key modulo bucket count. Mask for a power-of-two count,
// otherwise four 16-bit digits reduced in turn by reciprocal multiplication
// on one shared 17x17 multiplier, through M_EST, M_BACK and M_FIX per digit.
// ----------------------------------------------------------------------------
module chmif_mod_unit #(
    parameter int unsigned BUCKET_COUNT = chmif_pkg::BUCKET_COUNT_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            go,
    input  logic [chmif_pkg::KEY_W-1:0]     key,
    output logic                            done,
    output logic [$clog2(BUCKET_COUNT)-1:0] bucket
);

    localparam int unsigned     BW      = $clog2(BUCKET_COUNT);
    localparam int unsigned     XW      = BW + 16;
    localparam int unsigned     DIGITS  = chmif_pkg::KEY_W / 16;
    localparam bit              IS_POW2 = ((BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0);
    localparam longint unsigned RECIP   = (64'd1 << XW) / BUCKET_COUNT;
    localparam logic [16:0]     RECIP_V = 17'(RECIP);
    localparam logic [16:0]     MOD_V   = 17'(BUCKET_COUNT);
    localparam logic [XW-1:0]   MOD_X   = XW'(BUCKET_COUNT);
    localparam logic [XW-1:0]   MOD2_X  = XW'(2 * BUCKET_COUNT);

    typedef enum logic [1:0] {
        M_IDLE,
        M_EST,
        M_BACK,
        M_FIX
    } mod_state_t;

    mod_state_t                  state_reg;
    logic [BW-1:0]               rem_reg;
    logic [chmif_pkg::KEY_W-1:0] sh_reg;
    logic [1:0]                  digit_reg;
    logic [XW-1:0]               x_reg;
    logic [33:0]                 prod_reg;
    logic                        done_reg;
    logic [XW-1:0]               x_cur;
    logic [16:0]                 mul_a;
    logic [16:0]                 mul_b;
    logic [33:0]                 mul_p;
    logic [XW-1:0]               diff;
    logic [BW-1:0]               rem_fix;

    // estimate quotient from the top bits, then subtract q*M; estimate is
    // at most two short, so the fixup picks among three candidates
    assign x_cur = {rem_reg, sh_reg[chmif_pkg::KEY_W-1 -: 16]};
    assign mul_a = (state_reg == M_EST) ? x_cur[XW-1:BW-1] : prod_reg[33:17];
    assign mul_b = (state_reg == M_EST) ? RECIP_V : MOD_V;
    assign mul_p = 34'(mul_a) * 34'(mul_b);
    assign diff  = x_reg - prod_reg[XW-1:0];

    always_comb
    begin
        if (diff >= MOD2_X)
        begin
            rem_fix = BW'(diff - MOD2_X);
        end
        else if (diff >= MOD_X)
        begin
            rem_fix = BW'(diff - MOD_X);
        end
        else
        begin
            rem_fix = diff[BW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            done_reg  <= 1'b0;
            digit_reg <= '0;
            rem_reg   <= '0;
            sh_reg    <= '0;
            x_reg     <= '0;
            prod_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                M_IDLE:
                begin
                    if (go)
                    begin
                        if (IS_POW2)
                        begin
                            rem_reg  <= key[BW-1:0];
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            rem_reg   <= '0;
                            sh_reg    <= key;
                            digit_reg <= '0;
                            state_reg <= M_EST;
                        end
                    end
                end
                M_EST:
                begin
                    x_reg     <= x_cur;
                    prod_reg  <= mul_p;
                    sh_reg    <= {sh_reg[chmif_pkg::KEY_W-17:0], 16'h0000};
                    state_reg <= M_BACK;
                end
                M_BACK:
                begin
                    prod_reg  <= mul_p;
                    state_reg <= M_FIX;
                end
                M_FIX:
                begin
                    rem_reg   <= rem_fix;
                    digit_reg <= digit_reg + 1'b1;
                    if (digit_reg == 2'(DIGITS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= M_IDLE;
                    end
                    else
                    begin
                        state_reg <= M_EST;
                    end
                end
                default:
                begin
                    state_reg <= M_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

// File: hdl/chained_hash_map_insert_find_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_hash_map_insert_find_unit
// Hash table with separate chaining: find, insert-if-absent and clear.
// ----------------------------------------------------------------------------
// One operation at a time: start is taken while busy is low, and the result
// appears for exactly one cycle with done high; the receiver cannot stall it.
// After reset the unit sweeps the bucket head memory, one bucket per cycle,
// and holds busy high until the sweep is done. A find or insert reads the
// bucket head and then visits chain entries, each visit needing one entry
// memory read and one 64-bit key compare, after computing the remainder (four
// 16-bit digits on one shared multiplier) when BUCKET_COUNT is not a power
// of two. Insert of a new key adds a write state. The unused opcode goes only
// through S_MISC. Clear returns its result from S_MISC and then keeps busy
// high while the head memory is swept again.
// ----------------------------------------------------------------------------
`include "chained_hash_map_insert_find_unit_assert.svh"

module chained_hash_map_insert_find_unit #(
    parameter int unsigned BUCKET_COUNT   = chmif_pkg::BUCKET_COUNT_DEFAULT,
    parameter int unsigned ENTRY_CAPACITY = chmif_pkg::ENTRY_CAPACITY_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [chmif_pkg::OP_W-1:0]  opcode,
    input  logic [chmif_pkg::KEY_W-1:0] lookup_key,
    input  logic [chmif_pkg::VAL_W-1:0] entry_value,
    output logic                        busy,
    output logic                        done,
    output logic                        key_found,
    output logic                        entry_added,
    output logic                        store_full,
    output logic [chmif_pkg::VAL_W-1:0] result_value
);

    localparam int unsigned BW = $clog2(BUCKET_COUNT);
    localparam int unsigned EW = $clog2(ENTRY_CAPACITY);
    localparam int unsigned IW = $clog2(ENTRY_CAPACITY + 1);
    localparam logic [IW-1:0] LINK_NONE = IW'(ENTRY_CAPACITY);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_HEAD,
        S_HLOAD,
        S_ADDR,
        S_ENTRY,
        S_WRITE,
        S_MISC
    } state_t;

    state_t                        state_reg;
    logic [chmif_pkg::OP_W-1:0]    op_reg;
    logic [chmif_pkg::KEY_W-1:0]   key_reg;
    logic [chmif_pkg::VAL_W-1:0]   val_reg;
    logic [BW-1:0]                 bucket_reg;
    logic [BW-1:0]                 init_reg;
    logic [IW-1:0]                 idx_reg;
    logic [IW-1:0]                 head_reg;
    logic [IW-1:0]                 count_reg;
    logic                          done_reg;
    logic                          found_reg;
    logic                          added_reg;
    logic                          full_reg;
    logic [chmif_pkg::VAL_W-1:0]   res_reg;

    logic [IW-1:0]                 heads_mem [BUCKET_COUNT];
    logic [chmif_pkg::KEY_W-1:0]   key_mem   [ENTRY_CAPACITY];
    logic [chmif_pkg::VAL_W-1:0]   val_mem   [ENTRY_CAPACITY];
    logic [IW-1:0]                 link_mem  [ENTRY_CAPACITY];

    logic [IW-1:0]                 head_rd_reg;
    logic [chmif_pkg::KEY_W-1:0]   key_rd_reg;
    logic [chmif_pkg::VAL_W-1:0]   val_rd_reg;
    logic [IW-1:0]                 link_rd_reg;

    logic                          heads_we;
    logic [BW-1:0]                 heads_waddr;
    logic [IW-1:0]                 heads_wdata;
    logic                          entry_we;
    logic                          accept;
    logic                          mod_go;
    logic                          mod_done;
    logic [BW-1:0]                 mod_bucket;
    logic                          is_full;

    assign accept  = start && (state_reg == S_IDLE);
    assign mod_go  = accept && ((opcode == chmif_pkg::OP_FIND) ||
                                (opcode == chmif_pkg::OP_INSERT));
    assign is_full = (count_reg >= LINK_NONE);

    chmif_mod_unit #(
        .BUCKET_COUNT (BUCKET_COUNT)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mod_go),
        .key    (lookup_key),
        .done   (mod_done),
        .bucket (mod_bucket)
    );

    always_comb
    begin
        heads_we    = 1'b0;
        heads_waddr = bucket_reg;
        heads_wdata = count_reg;
        if (state_reg == S_INIT)
        begin
            heads_we    = 1'b1;
            heads_waddr = init_reg;
            heads_wdata = LINK_NONE;
        end
        else if (state_reg == S_WRITE)
        begin
            heads_we = 1'b1;
        end
    end

    assign entry_we = (state_reg == S_WRITE);

    always_ff @(posedge clk)
    begin
        if (heads_we)
        begin
            heads_mem[heads_waddr] <= heads_wdata;
        end
        head_rd_reg <= heads_mem[bucket_reg];
    end

    always_ff @(posedge clk)
    begin
        if (entry_we)
        begin
            key_mem[count_reg[EW-1:0]]  <= key_reg;
            val_mem[count_reg[EW-1:0]]  <= val_reg;
            link_mem[count_reg[EW-1:0]] <= head_reg;
        end
        key_rd_reg  <= key_mem[idx_reg[EW-1:0]];
        val_rd_reg  <= val_mem[idx_reg[EW-1:0]];
        link_rd_reg <= link_mem[idx_reg[EW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            init_reg   <= '0;
            count_reg  <= '0;
            done_reg   <= 1'b0;
            bucket_reg <= '0;
            idx_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_INIT:
                begin
                    init_reg <= init_reg + 1'b1;
                    if (init_reg == BW'(BUCKET_COUNT - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg  <= opcode;
                        key_reg <= lookup_key;
                        val_reg <= entry_value;
                        if (mod_go)
                        begin
                            state_reg <= S_HASH;
                        end
                        else
                        begin
                            state_reg <= S_MISC;
                        end
                    end
                end
                S_HASH:
                begin
                    if (mod_done)
                    begin
                        bucket_reg <= mod_bucket;
                        state_reg  <= S_HEAD;
                    end
                end
                S_HEAD:
                begin
                    state_reg <= S_HLOAD;
                end
                S_HLOAD:
                begin
                    idx_reg   <= head_rd_reg;
                    head_reg  <= head_rd_reg;
                    state_reg <= S_ADDR;
                end
                S_ADDR:
                begin
                    if (idx_reg >= count_reg)
                    begin
                        if ((op_reg == chmif_pkg::OP_INSERT) && !is_full)
                        begin
                            state_reg <= S_WRITE;
                        end
                        else
                        begin
                            done_reg  <= 1'b1;
                            found_reg <= 1'b0;
                            added_reg <= 1'b0;
                            full_reg  <= (op_reg == chmif_pkg::OP_INSERT);
                            res_reg   <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        state_reg <= S_ENTRY;
                    end
                end
                S_ENTRY:
                begin
                    if (key_rd_reg == key_reg)
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b1;
                        added_reg <= 1'b0;
                        full_reg  <= 1'b0;
                        res_reg   <= val_rd_reg;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        idx_reg   <= link_rd_reg;
                        state_reg <= S_ADDR;
                    end
                end
                S_WRITE:
                begin
                    count_reg <= count_reg + 1'b1;
                    done_reg  <= 1'b1;
                    found_reg <= 1'b0;
                    added_reg <= 1'b1;
                    full_reg  <= 1'b0;
                    res_reg   <= val_reg;
                    state_reg <= S_IDLE;
                end
                S_MISC:
                begin
                    done_reg  <= 1'b1;
                    found_reg <= 1'b0;
                    added_reg <= 1'b0;
                    full_reg  <= 1'b0;
                    res_reg   <= '0;
                    if (op_reg == chmif_pkg::OP_CLEAR)
                    begin
                        // stale heads would leave chains pointing at reused slots
                        count_reg <= '0;
                        init_reg  <= '0;
                        state_reg <= S_INIT;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy         = (state_reg != S_IDLE);
    assign done         = done_reg;
    assign key_found    = found_reg;
    assign entry_added  = added_reg;
    assign store_full   = full_reg;
    assign result_value = res_reg;

    `CHMIF_ASSERT_SAME(a_one_flag, clk, rst_n, done_reg, ($onehot0({found_reg, added_reg, full_reg})))
    `CHMIF_ASSERT_SAME(a_add_counts, clk, rst_n, (done_reg && added_reg), (count_reg == $past(count_reg) + 1'b1))
    `CHMIF_ASSERT_SAME(a_full_at_cap, clk, rst_n, (done_reg && full_reg), (count_reg == LINK_NONE))
    `CHMIF_ASSERT_NEXT(a_start_busy, clk, rst_n, accept, busy)
    `CHMIF_ASSERT_SAME(a_count_cap, clk, rst_n, 1'b1, (count_reg <= LINK_NONE))

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the chained hash map unit. A driver plays a queue
// of find, insert, clear and unused-opcode commands with random idle gaps.
// A monitor predicts each result from a shadow copy of the table. It then
// checks every result field. The stimulus covers short and long chains,
// filling the entry store up to the full condition, and clears.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned KEY_W       = chmif_pkg::KEY_W;
    localparam int unsigned VAL_W       = chmif_pkg::VAL_W;
    localparam int unsigned OP_W        = chmif_pkg::OP_W;
    localparam int unsigned CLK_PERIOD  = 10;
    localparam int unsigned BUCKETS     = chmif_pkg::BUCKET_COUNT_DEFAULT;
    localparam int unsigned ENTRY_CAP   = chmif_pkg::ENTRY_CAPACITY_DEFAULT;
    localparam int unsigned ITEM_TARGET = 1300;
    localparam int unsigned FILL_AFTER  = 200;
    localparam int unsigned DEEP_BUCKET = 5;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
        bit               settle;
    } map_cmd_t;

    typedef struct packed {
        logic             found;
        logic             added;
        logic             full;
        logic [VAL_W-1:0] value;
    } map_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic [OP_W-1:0]  opcode = '0;
    logic [KEY_W-1:0] lookup_key = '0;
    logic [VAL_W-1:0] entry_value = '0;
    logic             busy;
    logic             done;
    logic             key_found;
    logic             entry_added;
    logic             store_full;
    logic [VAL_W-1:0] result_value;

    // shadow table
    logic [KEY_W-1:0] map_keys [ENTRY_CAP];
    logic [VAL_W-1:0] map_vals [ENTRY_CAP];
    int unsigned      map_links [ENTRY_CAP];
    int unsigned      map_heads [BUCKETS];
    int unsigned      map_count;

    map_cmd_t    cmd_fifo [$];
    map_result_t pending_results [$];
    logic [KEY_W-1:0] live_keys [$];
    bit          start_taken;
    int unsigned idle_left;
    int unsigned calm_left;
    int unsigned n_items;
    int unsigned errors;

    chained_hash_map_insert_find_unit #(
        .BUCKET_COUNT   (BUCKETS),
        .ENTRY_CAPACITY (ENTRY_CAP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .lookup_key   (lookup_key),
        .entry_value  (entry_value),
        .busy         (busy),
        .done         (done),
        .key_found    (key_found),
        .entry_added  (entry_added),
        .store_full   (store_full),
        .result_value (result_value)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
    end

    function automatic void map_clear();
        for (int unsigned b = 0; b < BUCKETS; b++)
        begin
            map_heads[b] = ENTRY_CAP;
        end
        map_count = 0;
    endfunction

    function automatic bit map_lookup(input logic [KEY_W-1:0] key,
                                      output logic [VAL_W-1:0] val);
        int unsigned idx;
        val = '0;
        idx = map_heads[key % BUCKETS];
        for (int unsigned steps = 0; steps < ENTRY_CAP; steps++)
        begin
            if (idx >= map_count || idx >= ENTRY_CAP)
                return 1'b0;
            if (map_keys[idx] == key)
            begin
                val = map_vals[idx];
                return 1'b1;
            end
            idx = map_links[idx];
        end
        return 1'b0;
    endfunction

    function automatic map_result_t map_step(input logic [OP_W-1:0] op,
                                             input logic [KEY_W-1:0] key,
                                             input logic [VAL_W-1:0] val);
        map_result_t      res;
        logic [VAL_W-1:0] hit_val;
        int unsigned      b;
        res = '0;
        case (op)
            chmif_pkg::OP_FIND:
            begin
                if (map_lookup(key, hit_val))
                begin
                    res.found = 1'b1;
                    res.value = hit_val;
                end
            end
            chmif_pkg::OP_INSERT:
            begin
                if (map_lookup(key, hit_val))
                begin
                    res.found = 1'b1;
                    res.value = hit_val;
                end
                else if (map_count >= ENTRY_CAP)
                begin
                    res.full = 1'b1;
                end
                else
                begin
                    b = int'(key % BUCKETS);
                    map_keys[map_count]  = key;
                    map_vals[map_count]  = val;
                    map_links[map_count] = map_heads[b];
                    map_heads[b] = map_count;
                    map_count++;
                    res.added = 1'b1;
                    res.value = val;
                end
            end
            chmif_pkg::OP_CLEAR:
            begin
                map_clear();
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    function automatic int unsigned idle_len();
        int unsigned r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        if (r < 70)
            return $urandom_range(0, 3);
        if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [KEY_W-1:0] fresh_key(input int unsigned bucket);
        logic [KEY_W-1:0] k;
        k = {$urandom, $urandom};
        return k - (k % BUCKETS) + bucket;
    endfunction

    function automatic logic [VAL_W-1:0] rand_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    task automatic add_cmd(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                           input logic [VAL_W-1:0] val, input bit settle);
        map_cmd_t c;
        c.op     = op;
        c.key    = key;
        c.val    = val;
        c.settle = settle;
        cmd_fifo.insert(cmd_fifo.size(), c);
        n_items++;
        if (op == chmif_pkg::OP_INSERT)
            live_keys.insert(live_keys.size(), key);
        if (op == chmif_pkg::OP_CLEAR)
            live_keys.delete();
    endtask

    task automatic check_field(input string name, input logic [VAL_W-1:0] want,
                               input logic [VAL_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            errors++;
        end
    endtask

    // driver: inputs move on the falling edge
    always @(negedge clk)
    begin : drive_proc
        map_cmd_t c;
        if (rst_n && !(start && !start_taken))
        begin
            if (start && start_taken)
                idle_left = idle_len();
            start_taken = 1'b0;
            if (idle_left > 0)
            begin
                if (!busy)
                    idle_left--;
                start <= 1'b0;
            end
            else if (cmd_fifo.size() == 0 ||
                     (cmd_fifo[0].settle && pending_results.size() != 0))
            begin
                start <= 1'b0;
            end
            else
            begin
                c = cmd_fifo.pop_front();
                opcode      <= c.op;
                lookup_key  <= c.key;
                entry_value <= c.val;
                start       <= 1'b1;
            end
        end
    end

    // monitor: transfers sampled on the rising edge
    always @(posedge clk)
    begin : watch_proc
        map_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transfer with no command outstanding");
                    errors++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    check_field("key_found", VAL_W'(want.found), VAL_W'(key_found));
                    check_field("entry_added", VAL_W'(want.added), VAL_W'(entry_added));
                    check_field("store_full", VAL_W'(want.full), VAL_W'(store_full));
                    check_field("result_value", want.value, result_value);
                end
            end
            if (start && !busy)
            begin
                pending_results.insert(pending_results.size(),
                                       map_step(opcode, lookup_key, entry_value));
                start_taken = 1'b1;
            end
        end
    end

    initial
    begin : stim_proc
        int unsigned      r;
        int unsigned      burst;
        int unsigned      hot [3];
        bit               filled;
        logic [KEY_W-1:0] k;
        logic [OP_W-1:0]  op;

        map_clear();
        filled = 1'b0;

        // directed
        add_cmd(chmif_pkg::OP_FIND,   64'h0, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_INSERT, 64'h0, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_INSERT, '1, '1, 1'b0);
        add_cmd(chmif_pkg::OP_INSERT, 64'h0, '1, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   '1, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_INSERT, 64'h8000_0000_0000_0000, 32'hA5A5_A5A5, 1'b0);
        add_cmd(chmif_pkg::OP_INSERT, 64'h0000_0000_0000_0400, 32'h5A5A_5A5A, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   64'h0, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   64'h0000_0000_0000_0800, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   64'hFFFF_FFFF_FFFF_FBFF, 32'h0, 1'b0);
        add_cmd(OP_UNUSED, '1, '1, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   '1, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_CLEAR,  '1, '1, 1'b1);
        add_cmd(chmif_pkg::OP_FIND,   64'h0, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   '1, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_INSERT, 64'h5555_5555_5555_5555, 32'h5555_5555, 1'b0);
        add_cmd(chmif_pkg::OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'hAAAA_AAAA, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   64'h5555_5555_5555_5555, 32'h0, 1'b0);
        add_cmd(chmif_pkg::OP_FIND,   64'hAAAA_AAAA_AAAA_AAAA, 32'h0, 1'b0);

        // random
        while (n_items < ITEM_TARGET)
        begin
            if (!filled && n_items >= FILL_AFTER)
            begin
                // fill the store to capacity, one bucket gets a deep chain
                filled = 1'b1;
                add_cmd(chmif_pkg::OP_CLEAR, fresh_key(0), rand_value(), 1'b1);
                for (int unsigned i = 0; i < ENTRY_CAP + 6; i++)
                begin
                    k = fresh_key(($urandom_range(0, 4) == 0) ? DEEP_BUCKET
                                                              : $urandom_range(0, BUCKETS - 1));
                    add_cmd(chmif_pkg::OP_INSERT, k, rand_value(), i == ENTRY_CAP);
                end
                for (int unsigned i = 0; i < 12; i++)
                begin
                    k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                    add_cmd((i % 3 == 0) ? chmif_pkg::OP_INSERT : chmif_pkg::OP_FIND,
                            k, rand_value(), 1'b0);
                end
                add_cmd(chmif_pkg::OP_FIND, fresh_key(DEEP_BUCKET), rand_value(), 1'b0);
                add_cmd(chmif_pkg::OP_CLEAR, fresh_key(DEEP_BUCKET), rand_value(), 1'b0);
            end
            else if ($urandom_range(0, 11) == 0)
            begin
                add_cmd(chmif_pkg::OP_CLEAR, {$urandom, $urandom}, rand_value(),
                        $urandom_range(0, 3) == 0);
            end
            else
            begin
                hot[0] = $urandom_range(0, BUCKETS - 1);
                hot[1] = ($urandom_range(0, 1) == 0) ? 0 : BUCKETS - 1;
                hot[2] = $urandom_range(0, BUCKETS - 1);
                burst = $urandom_range(10, 40);
                for (int unsigned i = 0; i < burst; i++)
                begin
                    r = $urandom_range(0, 99);
                    op = (r < 45) ? chmif_pkg::OP_INSERT :
                         (r < 90) ? chmif_pkg::OP_FIND : OP_UNUSED;
                    if (live_keys.size() != 0 && $urandom_range(0, 99) < 40)
                        k = live_keys[$urandom_range(0, live_keys.size() - 1)];
                    else if ($urandom_range(0, 9) < 7)
                        k = fresh_key(hot[$urandom_range(0, 2)]);
                    else
                        k = fresh_key($urandom_range(0, BUCKETS - 1));
                    add_cmd(op, k, rand_value(), $urandom_range(0, 63) == 0);
                end
            end
        end

        while (cmd_fifo.size() != 0 || start || pending_results.size() != 0)
            @(posedge clk);
        repeat (32) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin : watchdog_proc
        #50ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// File: sim.f
+incdir+hdl
hdl/chmif_pkg.sv
hdl/chmif_mod_unit.sv
hdl/chained_hash_map_insert_find_unit.sv
sim/testbench.sv
